// ===== rtl/core/hsl_pkg.sv =====
// Shared types, fixed-point constants and helpers for the HSL to RGB converter.
// No dependencies; imported by every module of the block.
package hsl_pkg;

  localparam int unsigned FX_W  = 17;
  localparam int unsigned HUE_W = 16;

  typedef logic [FX_W-1:0]  fx_t;
  typedef logic [HUE_W-1:0] hue_t;

  // 1.0 and 0.5 in 16-fraction-bit fixed point
  localparam fx_t  FX_ONE    = 17'h10000;
  localparam fx_t  FX_HALF   = 17'h08000;
  // one third of a turn, and the same offset going the other way
  localparam hue_t HUE_THIRD     = 16'd21845;
  localparam hue_t HUE_NEG_THIRD = 16'd43691;

  localparam int unsigned LANE_CNT   = 3;
  localparam int unsigned LANE_RED   = 0;
  localparam int unsigned LANE_GREEN = 1;
  localparam int unsigned LANE_BLUE  = 2;

  // hue ramp segments, selected from 6*t
  typedef logic [1:0] seg_t;
  localparam seg_t SEG_RISE = 2'd0;
  localparam seg_t SEG_HIGH = 2'd1;
  localparam seg_t SEG_FALL = 2'd2;
  localparam seg_t SEG_LOW  = 2'd3;

  // one queued request: the two levels, the hue and the pass-through alpha
  typedef struct packed {
    fx_t  p;
    fx_t  q;
    hue_t hue;
    fx_t  alpha;
  } hsl_item_t;

  // saturate a non-negative 19-bit value to 0..1.0
  function automatic fx_t clamp_one(input logic [FX_W+1:0] v);
    fx_t res;
    if (v > {2'b00, FX_ONE}) begin
      res = FX_ONE;
    end else begin
      res = v[FX_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/hsl_front.sv =====
// Front end: accepts a request, clamps S and L, forms L*S and then the levels q and p.
// Depends on hsl_pkg.
module hsl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hsl_pkg::hue_t      in_hue,
  input  hsl_pkg::fx_t       in_saturation,
  input  hsl_pkg::fx_t       in_lightness,
  input  hsl_pkg::fx_t       in_alpha_in,
  output logic               push_valid,
  input  logic               push_stall,
  output hsl_pkg::hsl_item_t push_item
);
  import hsl_pkg::*;

  fx_t               s_c;
  fx_t               l_c;
  logic [2*FX_W-1:0] prod_c;
  logic              a_load;
  logic              a_valid_r;
  logic              a_valid_nxt;
  fx_t               a_s_r;
  fx_t               a_l_r;
  fx_t               a_ls_r;
  hue_t              a_hue_r;
  fx_t               a_alpha_r;
  logic [FX_W+1:0]   qv_c;
  logic [FX_W+1:0]   l2_c;
  fx_t               q_c;
  fx_t               p_c;

  assign s_c    = (in_saturation > FX_ONE) ? FX_ONE : in_saturation;
  assign l_c    = (in_lightness > FX_ONE) ? FX_ONE : in_lightness;
  assign prod_c = l_c * s_c;

  assign in_stall    = a_valid_r && push_stall;
  assign a_load      = in_valid && !in_stall;
  assign a_valid_nxt = a_load || (a_valid_r && push_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_s_r     <= s_c;
      a_l_r     <= l_c;
      a_ls_r    <= prod_c[2*FX_W-2:FX_W-1];
      a_hue_r   <= in_hue;
      a_alpha_r <= in_alpha_in;
    end
  end

  // q and p; zero saturation falls out as q = p = L
  always_comb begin
    if (a_l_r < FX_HALF) begin
      qv_c = {2'b00, a_l_r} + {2'b00, a_ls_r};
    end else begin
      qv_c = {2'b00, a_l_r} + {2'b00, a_s_r} - {2'b00, a_ls_r};
    end
    q_c  = clamp_one(qv_c);
    l2_c = {1'b0, a_l_r, 1'b0};
    if (l2_c < {2'b00, q_c}) begin
      p_c = '0;
    end else begin
      p_c = clamp_one(l2_c - {2'b00, q_c});
    end
    if (p_c > q_c) begin
      p_c = q_c;
    end
  end

  assign push_valid      = a_valid_r;
  assign push_item.p     = p_c;
  assign push_item.q     = q_c;
  assign push_item.hue   = a_hue_r;
  assign push_item.alpha = a_alpha_r;

endmodule

// ===== rtl/core/hsl_queue.sv =====
// Short request queue between front and back end, register based.
// Depends on hsl_pkg.
module hsl_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_stall,
  input  hsl_pkg::hsl_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_stall,
  output hsl_pkg::hsl_item_t pop_item
);
  import hsl_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hsl_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push;
  logic             pop;

  assign push_stall = (count_r == CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill count lost a push");
`endif

endmodule

// ===== rtl/core/hsl_back.sv =====
// Back end: evaluates the hue ramp for red, green and blue and holds the result.
// Depends on hsl_pkg.
module hsl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_stall,
  input  hsl_pkg::hsl_item_t pop_item,
  output logic               out_valid,
  input  logic               out_stall,
  output hsl_pkg::fx_t       out_red,
  output hsl_pkg::fx_t       out_green,
  output hsl_pkg::fx_t       out_blue,
  output hsl_pkg::fx_t       out_alpha_out
);
  import hsl_pkg::*;

  hue_t              t_c    [LANE_CNT];
  logic [FX_W+1:0]   u_c    [LANE_CNT];
  seg_t              seg_c  [LANE_CNT];
  fx_t               mul_c  [LANE_CNT];
  logic [2*FX_W-1:0] prod_c [LANE_CNT];
  fx_t               d_c;
  seg_t              b1_seg_r  [LANE_CNT];
  fx_t               b1_frac_r [LANE_CNT];
  fx_t               b1_p_r;
  fx_t               b1_q_r;
  fx_t               b1_alpha_r;
  logic              b1_valid_r;
  logic              b1_valid_nxt;
  logic              b1_load;
  logic              b1_ready;
  fx_t               v_c [LANE_CNT];
  logic              out_ready;
  logic              out_load;
  logic              out_valid_r;
  logic              out_valid_nxt;
  fx_t               out_red_r;
  fx_t               out_green_r;
  fx_t               out_blue_r;
  fx_t               out_alpha_r;

  assign out_ready     = !out_valid_r || !out_stall;
  assign b1_ready      = !b1_valid_r || out_ready;
  assign pop_stall     = !b1_ready;
  assign b1_load       = pop_valid && b1_ready;
  assign b1_valid_nxt  = b1_load || (b1_valid_r && !out_ready);
  assign out_load      = b1_valid_r && out_ready;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  assign d_c    = pop_item.q - pop_item.p;
  assign t_c[LANE_RED]   = pop_item.hue + HUE_THIRD;
  assign t_c[LANE_GREEN] = pop_item.hue;
  assign t_c[LANE_BLUE]  = pop_item.hue + HUE_NEG_THIRD;

  // stage 1: pick the segment and the ramp position, multiply by q - p
  always_comb begin
    for (int i = 0; i < LANE_CNT; i++) begin
      u_c[i] = {t_c[i], 2'b00} + {1'b0, t_c[i], 1'b0};
      case (u_c[i][FX_W+1:FX_W-1])
        3'd0: begin
          seg_c[i] = SEG_RISE;
          mul_c[i] = {1'b0, u_c[i][FX_W-2:0]};
        end
        3'd1, 3'd2: begin
          seg_c[i] = SEG_HIGH;
          mul_c[i] = '0;
        end
        3'd3: begin
          seg_c[i] = SEG_FALL;
          mul_c[i] = FX_ONE - {1'b0, u_c[i][FX_W-2:0]};
        end
        default: begin
          seg_c[i] = SEG_LOW;
          mul_c[i] = '0;
        end
      endcase
      prod_c[i] = d_c * mul_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b1_valid_r  <= b1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_load) begin
      for (int i = 0; i < LANE_CNT; i++) begin
        b1_seg_r[i]  <= seg_c[i];
        b1_frac_r[i] <= prod_c[i][2*FX_W-2:FX_W-1];
      end
      b1_p_r     <= pop_item.p;
      b1_q_r     <= pop_item.q;
      b1_alpha_r <= pop_item.alpha;
    end
  end

  // stage 2: rise and fall add the lower level and saturate; high takes q, low p
  always_comb begin
    for (int i = 0; i < LANE_CNT; i++) begin
      case (b1_seg_r[i])
        SEG_RISE, SEG_FALL: v_c[i] = clamp_one({2'b00, b1_p_r} + {2'b00, b1_frac_r[i]});
        SEG_HIGH:           v_c[i] = b1_q_r;
        default:            v_c[i] = b1_p_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= v_c[LANE_RED];
      out_green_r <= v_c[LANE_GREEN];
      out_blue_r  <= v_c[LANE_BLUE];
      out_alpha_r <= b1_alpha_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_alpha_out = out_alpha_r;

`ifndef NO_ASSERTIONS
  a_b1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b1_valid_r && !out_ready) |=> (b1_valid_r && $stable(b1_p_r) && $stable(b1_q_r)))
    else $error("ramp stage dropped a held request");
`endif

endmodule

// ===== rtl/core/hsl_to_rgb_converter.sv =====
// Top level of the HSL to RGB converter: front end, request queue, ramp back end.
// Depends on hsl_pkg, hsl_front, hsl_queue and hsl_back.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------
//   in      | in_hue, in_saturation, in_lightness,    | in_valid/in_stall
//           | in_alpha_in                             |
//   out     | out_red, out_green, out_blue,           | out_valid/out_stall
//           | out_alpha_out                           |
//
// Throughput: one request per cycle while out_stall is low; the queue pushes and
// pops in the same cycle, so front and back end each move one request a cycle.
// Path: an accepted request loads the front register, then a queue slot, the ramp
// multiply register and the output register, which drives out_valid.
// Reset: synchronous, clears valid flags, queue pointers and count only; no sweep.
// Stalls: out_stall holds the output and ramp stages; the front end accepts until
// the QUEUE_DEPTH-entry queue and its register are full, then raises in_stall.
module hsl_to_rgb_converter #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hsl_pkg::hue_t in_hue,
  input  hsl_pkg::fx_t  in_saturation,
  input  hsl_pkg::fx_t  in_lightness,
  input  hsl_pkg::fx_t  in_alpha_in,
  output logic          out_valid,
  input  logic          out_stall,
  output hsl_pkg::fx_t  out_red,
  output hsl_pkg::fx_t  out_green,
  output hsl_pkg::fx_t  out_blue,
  output hsl_pkg::fx_t  out_alpha_out
);
  import hsl_pkg::*;

  // front end to queue
  logic      push_valid;
  logic      push_stall;
  hsl_item_t push_item;
  // queue to back end
  logic      pop_valid;
  logic      pop_stall;
  hsl_item_t pop_item;

  // clamp S and L, form q and p
  hsl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .in_alpha_in   (in_alpha_in),
    .push_valid    (push_valid),
    .push_stall    (push_stall),
    .push_item     (push_item)
  );

  // decouple the two halves so each can stall on its own
  hsl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_item   (pop_item)
  );

  // evaluate the hue ramp for the three channels
  hsl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_stall     (pop_stall),
    .pop_item      (pop_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha_out (out_alpha_out)
  );

`ifndef NO_ASSERTIONS
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_red <= FX_ONE) && (out_green <= FX_ONE) && (out_blue <= FX_ONE)))
    else $error("color channel above 1.0");

  a_zero_sat_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && (push_item.p == push_item.q)) |-> (push_item.q <= FX_ONE))
    else $error("level out of range on grey request");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for hsl_to_rgb_converter: HSL pixels in, RGBA pixels checked out.
// Depends on hsl_pkg (field types, fixed-point constants) and the converter RTL.
// Prediction is a local fixed-point HSL model; both channels idle and stall at random.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsl_pkg::*;

  // one input request and one output pixel, fields in port order
  typedef struct packed {
    hue_t hue;
    fx_t  sat;
    fx_t  light;
    fx_t  alpha;
  } hsl_pixel_t;

  typedef struct packed {
    fx_t red;
    fx_t green;
    fx_t blue;
    fx_t alpha;
  } rgba_pixel_t;

  localparam int unsigned     RANDOM_PIXELS = 800;
  localparam int unsigned     DRAIN_CYCLES  = 20;   // extra wait for a stray pixel after the last one
  localparam longint          UNIT          = 65536;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic in_valid      = 1'b0;
  logic in_stall;
  hue_t in_hue        = '0;
  fx_t  in_saturation = '0;
  fx_t  in_lightness  = '0;
  fx_t  in_alpha_in   = '0;

  // result channel
  logic out_valid;
  logic out_stall     = 1'b0;
  fx_t  out_red;
  fx_t  out_green;
  fx_t  out_blue;
  fx_t  out_alpha_out;

  hsl_pixel_t  pending_pixels[$];   // requests not yet offered to the block
  rgba_pixel_t expected_rgba[$];    // predicted pixels, oldest first
  rgba_pixel_t got_rgba;
  rgba_pixel_t want_rgba;
  int unsigned pixel_total     = 0;
  int unsigned pixels_accepted = 0;
  int unsigned mismatch_count  = 0;

  hsl_to_rgb_converter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha_out (out_alpha_out)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // saturate a signed intermediate to 0..1.0
  function automatic fx_t limit_unit(longint v);
    if (v < 0) begin
      return '0;
    end
    if (v > UNIT) begin
      return fx_t'(UNIT);
    end
    return fx_t'(v);
  endfunction

  // piecewise-linear hue ramp between the low level lo and the high level hi;
  // u = 6*pos splits the turn into rise, hold-high, fall and hold-low sections
  function automatic fx_t hue_ramp(fx_t lo, fx_t hi, hue_t pos);
    longint span;
    longint u;
    longint v;
    span = longint'(hi) - longint'(lo);
    u    = 6 * longint'(pos);
    if (u < UNIT) begin
      v = longint'(lo) + ((span * u) >>> 16);
    end else if (u < 3 * UNIT) begin
      v = longint'(hi);
    end else if (u < 4 * UNIT) begin
      v = longint'(lo) + ((span * (4 * UNIT - u)) >>> 16);
    end else begin
      v = longint'(lo);
    end
    return limit_unit(v);
  endfunction

  // full conversion of one request into the pixel the block should return
  function automatic rgba_pixel_t hsl_to_rgba(hsl_pixel_t px);
    longint      s;
    longint      l;
    longint      ls;
    longint      qv;
    fx_t         q;
    fx_t         p;
    hue_t        hue_red;
    hue_t        hue_blue;
    rgba_pixel_t res;
    // clamp saturation and lightness to one before anything else
    s  = (longint'(px.sat) > UNIT) ? UNIT : longint'(px.sat);
    l  = (longint'(px.light) > UNIT) ? UNIT : longint'(px.light);
    res.alpha = px.alpha;   // alpha passes through unclamped
    if (s == 0) begin
      // gray: every channel is the lightness
      res.red   = fx_t'(l);
      res.green = fx_t'(l);
      res.blue  = fx_t'(l);
    end else begin
      ls = (l * s) >>> 16;
      if (l < UNIT / 2) begin
        qv = l + ls;
      end else begin
        qv = l + s - ls;
      end
      q = limit_unit(qv);
      p = limit_unit(2 * l - longint'(q));
      if (p > q) begin
        p = q;
      end
      // red leads by a third of a turn, blue lags by one; both wrap
      hue_red  = px.hue + HUE_THIRD;
      hue_blue = px.hue - HUE_THIRD;
      res.red   = hue_ramp(p, q, hue_red);
      res.green = hue_ramp(p, q, px.hue);
      res.blue  = hue_ramp(p, q, hue_blue);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle schedule: sender 27% / receiver 61%, then swapped, then no idling.
  // The phase follows how many requests the block has taken so far.
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_percent(bit sender, int unsigned done,
                                               int unsigned total);
    if (done < total / 3) begin
      return sender ? 27 : 61;
    end
    if (done < (2 * total) / 3) begin
      return sender ? 61 : 27;
    end
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: hold a stalled request, otherwise offer the next one or idle.
  // A request taken at this edge gets its prediction queued right here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rgba.push_back(
          hsl_to_rgba('{in_hue, in_saturation, in_lightness, in_alpha_in}));
        pixels_accepted <= pixels_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 &&
            $urandom_range(99) >= idle_percent(1'b1, pixels_accepted, pixel_total)) begin
          in_hue        <= pending_pixels[0].hue;
          in_saturation <= pending_pixels[0].sat;
          in_lightness  <= pending_pixels[0].light;
          in_alpha_in   <= pending_pixels[0].alpha;
          in_valid      <= 1'b1;
          void'(pending_pixels.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check every accepted pixel against the oldest prediction and
  // drive out_stall for the next edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_rgba = '{out_red, out_green, out_blue, out_alpha_out};
        if (expected_rgba.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d, none pending",
                   $time, got_rgba.red, got_rgba.green, got_rgba.blue, got_rgba.alpha);
        end else begin
          want_rgba = expected_rgba.pop_front();
          if (got_rgba !== want_rgba) begin
            mismatch_count++;
            $display({"%0t: pixel differs: expected r=%0d g=%0d b=%0d a=%0d,",
                      " got r=%0d g=%0d b=%0d a=%0d"},
                     $time, want_rgba.red, want_rgba.green, want_rgba.blue,
                     want_rgba.alpha, got_rgba.red, got_rgba.green, got_rgba.blue,
                     got_rgba.alpha);
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_percent(1'b0, pixels_accepted, pixel_total));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_pixel(hue_t h, fx_t s, fx_t l, fx_t a);
    pending_pixels.push_back('{h, s, l, a});
  endtask

  // level field: mostly in range, with zero, one and above-one values mixed in
  function automatic fx_t pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return FX_ONE;
      2:       return fx_t'($urandom_range(131071, 65537));
      3:       return fx_t'($urandom_range(32769, 32767));
      default: return fx_t'($urandom_range(65536));
    endcase
  endfunction

  // hue: full range, with the ramp section edges hit now and then
  function automatic hue_t pick_hue();
    case ($urandom_range(9))
      0:       return hue_t'(10922 + $urandom_range(1));
      1:       return hue_t'(32767 + $urandom_range(1));
      2:       return hue_t'(43690 + $urandom_range(1));
      3:       return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      default: return hue_t'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    // gray pixels, including lightness above one and alpha above one
    add_pixel(16'd1234,  17'd0,      17'd40000,  17'd65536);
    add_pixel(16'd65535, 17'd0,      17'd131071, 17'd131071);
    add_pixel(16'd0,     17'd0,      17'd0,      17'd0);
    // primaries at full saturation, half lightness
    add_pixel(16'd0,     17'd65536,  17'd32768,  17'd65536);
    add_pixel(HUE_THIRD, 17'd65536,  17'd32768,  17'd65536);
    add_pixel(HUE_NEG_THIRD, 17'd65536, 17'd32768, 17'd65536);
    // both sides of every ramp section edge
    add_pixel(16'd10922, 17'd131071, 17'd32767,  17'd1000);
    add_pixel(16'd10923, 17'd65536,  17'd32768,  17'd2000);
    add_pixel(16'd32767, 17'd50000,  17'd20000,  17'd3000);
    add_pixel(16'd32768, 17'd50000,  17'd20000,  17'd4000);
    add_pixel(16'd43690, 17'd50000,  17'd50000,  17'd5000);
    add_pixel(16'd43691, 17'd50000,  17'd50000,  17'd6000);
    add_pixel(16'd65535, 17'd1,      17'd65535,  17'd7000);
    // saturation and lightness above one are clamped first
    add_pixel(16'd5000,  17'd65536,  17'd131071, 17'd8000);
    add_pixel(16'd20000, 17'd30000,  17'd65536,  17'd9000);
    add_pixel(16'd8000,  17'd65536,  17'd1,      17'd10000);
    add_pixel(16'd30000, 17'd1,      17'd1,      17'd1);
    add_pixel(16'd40000, 17'd100000, 17'd100000, 17'd100000);
    // alternating bit patterns on every field
    add_pixel(16'h5555,  17'h15555,  17'h0AAAA,  17'h0AAAA);
    add_pixel(16'hAAAA,  17'h0AAAA,  17'h15555,  17'h15555);

    repeat (RANDOM_PIXELS) begin
      add_pixel(pick_hue(), pick_level(), pick_level(), fx_t'($urandom_range(131071)));
    end
    pixel_total = pending_pixels.size();

    // hold reset low, then release it once
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every request to be taken and every pixel to come back
    while (pixels_accepted < pixel_total) @(posedge clk);
    while (expected_rgba.size() != 0) @(posedge clk);
    // give a stray extra pixel time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
